FILE: rtl/hairq_pkg.sv
package hairq_pkg;

  localparam int BATCH_W = 7;
  localparam logic [BATCH_W-1:0] BATCH_RESET = 7'd32;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_PULL   = 2'd1;
  localparam logic [1:0] CMD_PEEK   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] CLS_READ     = 2'd0;
  localparam logic [1:0] CLS_WRITE    = 2'd1;
  localparam logic [1:0] CLS_CONFLICT = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_SPAN  = 2'd2;
  localparam logic [1:0] STS_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD      = 2'd0,
    OP_LOAD_NEW  = 2'd1,
    OP_SHIFT     = 2'd2,
    OP_LOAD_TAIL = 2'd3
  } cell_op_e;

endpackage

FILE: rtl/hairq_cell.sv
module hairq_cell #(
  parameter int FB_W = 28,
  parameter int SP_W = 4
) (
  input  logic                  clk_i,
  input  hairq_pkg::cell_op_e   op_i,
  input  logic                  valid_i,
  input  logic [FB_W:0]         blk_i,
  input  logic [3:0]            qfile_i,
  input  logic [7:0]            new_tag_i,
  input  logic [3:0]            new_file_i,
  input  logic [FB_W-1:0]       new_first_i,
  input  logic [SP_W-1:0]       new_span_i,
  input  logic [1:0]            new_cls_i,
  input  logic [7:0]            nb_tag_i,
  input  logic [3:0]            nb_file_i,
  input  logic [FB_W-1:0]       nb_first_i,
  input  logic [SP_W-1:0]       nb_span_i,
  input  logic [1:0]            nb_cls_i,
  input  logic [7:0]            tl_tag_i,
  input  logic [3:0]            tl_file_i,
  input  logic [FB_W-1:0]       tl_first_i,
  input  logic [SP_W-1:0]       tl_span_i,
  output logic [7:0]            tag_o,
  output logic [3:0]            file_o,
  output logic [FB_W-1:0]       first_o,
  output logic [SP_W-1:0]       span_o,
  output logic [1:0]            cls_o,
  output logic                  cover_o
);
  import hairq_pkg::*;

  logic [7:0]      tag_q;
  logic [3:0]      file_q;
  logic [FB_W-1:0] first_q;
  logic [SP_W-1:0] span_q;
  logic [1:0]      cls_q;
  logic [FB_W:0]   lo;

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LOAD_NEW: begin
        tag_q   <= new_tag_i;
        file_q  <= new_file_i;
        first_q <= new_first_i;
        span_q  <= new_span_i;
        cls_q   <= new_cls_i;
      end
      OP_SHIFT: begin
        tag_q   <= nb_tag_i;
        file_q  <= nb_file_i;
        first_q <= nb_first_i;
        span_q  <= nb_span_i;
        cls_q   <= nb_cls_i;
      end
      OP_LOAD_TAIL: begin
        tag_q   <= tl_tag_i;
        file_q  <= tl_file_i;
        first_q <= tl_first_i;
        span_q  <= tl_span_i;
        cls_q   <= CLS_CONFLICT;
      end
      default: begin
      end
    endcase
  end

  assign lo      = {1'b0, first_q};
  assign cover_o = valid_i && (file_q == qfile_i) && (blk_i >= lo) &&
                   (blk_i < (lo + (FB_W+1)'(span_q)));
  assign tag_o   = tag_q;
  assign file_o  = file_q;
  assign first_o = first_q;
  assign span_o  = span_q;
  assign cls_o   = cls_q;

endmodule

FILE: rtl/hairq_div.sv
module hairq_div #(
  parameter int NUM_W = 13,
  parameter int DEN_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d, den_q;
  logic [DEN_W:0]   trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[NUM_W-1]};
    if (start_i) begin
      cnt_d = CW'(NUM_W);
      num_d = num_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DEN_W'(trial - {1'b0, den_q});
        num_d = {num_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DEN_W-1:0];
        num_d = {num_q[NUM_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

FILE: rtl/hazard_aware_io_reorder_queue.sv
// push: checks each block of the span, moves covering writes (and reads, for a write), then appends
// a refused push or an unused command goes straight to the result
// pull and peek: pick a class and its oldest entry, refilling the budgets first when none is left
//   (three quotients from one bit-serial divider)
// one item at a time; the next is taken once the result sits in the output register
// reset empties the queue, clears the budgets and sets the grant quota to 32
module hazard_aware_io_reorder_queue #(
  parameter int QUEUE_DEPTH     = 32,
  parameter int BLOCK_BYTES     = 4096,
  parameter int MAX_SPAN_BLOCKS = 8,
  parameter int FILE_COUNT      = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          grant_quota_we_i,
  input  logic [hairq_pkg::BATCH_W-1:0] grant_quota_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic                          is_write_i,
  input  logic [3:0]                    file_id_i,
  input  logic [39:0]                   byte_offset_i,
  input  logic [15:0]                   byte_length_i,
  input  logic [7:0]                    request_tag_i,
  output logic                          res_valid_o,
  input  logic                          res_stall_i,
  output logic [1:0]                    status_o,
  output logic                          pushed_conflicting_o,
  output logic [5:0]                    moved_count_o,
  output logic                          out_valid_o,
  output logic [7:0]                    out_tag_o,
  output logic [1:0]                    out_class_o
);
  import hairq_pkg::*;

  // block size must be a power of two; the module itself does not enforce it
  localparam int SHIFT = $clog2(BLOCK_BYTES);
  localparam int FB_W  = 40 - SHIFT;
  localparam int BLK_W = FB_W + 1;
  localparam int SP_W  = $clog2(MAX_SPAN_BLOCKS + 1);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int NUM_W = CNT_W + BATCH_W;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_CONF    = 9'b000000010,
    S_WR      = 9'b000000100,
    S_RD      = 9'b000001000,
    S_APPEND  = 9'b000010000,
    S_SEL     = 9'b000100000,
    S_DIVGO   = 9'b001000000,
    S_DIVWAIT = 9'b010000000,
    S_FIN     = 9'b100000000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, nr_q, nr_d, nw_q, nw_d, nc_q, nc_d;
  logic [BATCH_W-1:0] rb_q, rb_d, wb_q, wb_d, cb_q, cb_d, batch_q;
  logic [SP_W-1:0]    k_q, k_d, span_q, span_d;
  logic [FB_W-1:0]    first_q, first_d;
  logic [3:0]         file_q, file_d;
  logic               wr_q, wr_d, conf_q, conf_d, spend_q, spend_d;
  logic [7:0]         tag_q, tag_d;
  logic [5:0]         moved_q, moved_d;
  logic [1:0]         dsel_q, dsel_d;
  logic [1:0]         r_status_q, r_status_d, r_class_q, r_class_d;
  logic               r_oval_q, r_oval_d;
  logic [7:0]         r_tag_q, r_tag_d;
  logic               res_valid_q;
  logic               push_done_q;

  // push decode
  logic [3:0]        fmod [16];
  logic [SHIFT:0]    room;
  logic [16:0]       len17, room17, minlr, rest;
  logic [17:0]       nblk;

  for (genvar g = 0; g < 16; g++) begin : g_fmod
    assign fmod[g] = 4'(g % FILE_COUNT);
  end

  assign room   = (SHIFT+1)'(BLOCK_BYTES) - {1'b0, byte_offset_i[SHIFT-1:0]};
  assign len17  = {1'b0, byte_length_i};
  assign room17 = 17'(room);
  assign minlr  = (len17 < room17) ? len17 : room17;
  assign rest   = len17 - minlr;
  assign nblk   = 18'((18'(rest) + 18'(BLOCK_BYTES - 1)) >> SHIFT) + 18'd1;

  // cell row
  cell_op_e         c_op    [QUEUE_DEPTH];
  logic [7:0]       c_tag   [QUEUE_DEPTH];
  logic [3:0]       c_file  [QUEUE_DEPTH];
  logic [FB_W-1:0]  c_first [QUEUE_DEPTH];
  logic [SP_W-1:0]  c_span  [QUEUE_DEPTH];
  logic [1:0]       c_cls   [QUEUE_DEPTH];
  logic             c_cover [QUEUE_DEPTH];
  logic             c_vld   [QUEUE_DEPTH];
  logic [BLK_W-1:0] blk;
  logic [1:0]       new_cls;

  logic             mv_en, pl_en, app_en;
  logic [IDX_W-1:0] mv_idx, pl_idx;

  assign blk     = BLK_W'(first_q) + BLK_W'(k_q);
  assign new_cls = conf_q ? CLS_CONFLICT : (wr_q ? CLS_WRITE : CLS_READ);

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    localparam int NB = (g == QUEUE_DEPTH - 1) ? g : g + 1;

    assign c_vld[g] = CNT_W'(g) < cnt_q;

    always_comb begin
      c_op[g] = OP_HOLD;
      if (app_en && CNT_W'(g) == cnt_q) begin
        c_op[g] = OP_LOAD_NEW;
      end else if (mv_en) begin
        if (CNT_W'(g) == cnt_q - CNT_W'(1)) c_op[g] = OP_LOAD_TAIL;
        else if (IDX_W'(g) >= mv_idx && CNT_W'(g) < cnt_q) c_op[g] = OP_SHIFT;
      end else if (pl_en && IDX_W'(g) >= pl_idx && CNT_W'(g) < cnt_q) begin
        c_op[g] = OP_SHIFT;
      end
    end

    hairq_cell #(.FB_W(FB_W), .SP_W(SP_W)) u_cell (
      .clk_i       (clk_i),
      .op_i        (c_op[g]),
      .valid_i     (c_vld[g]),
      .blk_i       (blk),
      .qfile_i     (file_q),
      .new_tag_i   (tag_q),
      .new_file_i  (file_q),
      .new_first_i (first_q),
      .new_span_i  (span_q),
      .new_cls_i   (new_cls),
      .nb_tag_i    (c_tag[NB]),
      .nb_file_i   (c_file[NB]),
      .nb_first_i  (c_first[NB]),
      .nb_span_i   (c_span[NB]),
      .nb_cls_i    (c_cls[NB]),
      .tl_tag_i    (c_tag[mv_idx]),
      .tl_file_i   (c_file[mv_idx]),
      .tl_first_i  (c_first[mv_idx]),
      .tl_span_i   (c_span[mv_idx]),
      .tag_o       (c_tag[g]),
      .file_o      (c_file[g]),
      .first_o     (c_first[g]),
      .span_o      (c_span[g]),
      .cls_o       (c_cls[g]),
      .cover_o     (c_cover[g])
    );
  end

  // oldest covering entries and class heads (lowest position is oldest)
  logic             any_c, hit_w, hit_r, hd_found;
  logic [IDX_W-1:0] w_idx, r_idx, hd_idx;
  logic             sel_found;
  logic [1:0]       sel_cls;

  always_comb begin
    any_c = 1'b0;
    hit_w = 1'b0;
    hit_r = 1'b0;
    w_idx = '0;
    r_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (c_cover[i] && c_cls[i] == CLS_CONFLICT) any_c = 1'b1;
      if (c_cover[i] && c_cls[i] == CLS_WRITE) begin
        hit_w = 1'b1;
        w_idx = IDX_W'(i);
      end
      if (c_cover[i] && c_cls[i] == CLS_READ) begin
        hit_r = 1'b1;
        r_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    sel_found = 1'b1;
    sel_cls   = CLS_READ;
    if (rb_q != '0 && nr_q != '0)      sel_cls = CLS_READ;
    else if (wb_q != '0 && nw_q != '0) sel_cls = CLS_WRITE;
    else if (cb_q != '0 && nc_q != '0) sel_cls = CLS_CONFLICT;
    else                               sel_found = 1'b0;
  end

  always_comb begin
    hd_found = 1'b0;
    hd_idx   = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (c_vld[i] && c_cls[i] == sel_cls) begin
        hd_found = 1'b1;
        hd_idx   = IDX_W'(i);
      end
    end
  end

  // budget refill divider
  logic             div_start, div_done;
  logic [CNT_W-1:0] div_cnt;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [BATCH_W-1:0] refill;

  always_comb begin
    unique case (dsel_q)
      CLS_READ:  div_cnt = nr_q;
      CLS_WRITE: div_cnt = nw_q;
      default:   div_cnt = nc_q;
    endcase
  end

  assign div_num = NUM_W'(div_cnt) * NUM_W'(batch_q);
  assign refill  = (div_quo == '0) ? BATCH_W'(1) : div_quo[BATCH_W-1:0];

  hairq_div #(.NUM_W(NUM_W), .DEN_W(CNT_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (cnt_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  logic accept, out_free;
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !res_valid_q || !res_stall_i;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    nr_d       = nr_q;
    nw_d       = nw_q;
    nc_d       = nc_q;
    rb_d       = rb_q;
    wb_d       = wb_q;
    cb_d       = cb_q;
    k_d        = k_q;
    span_d     = span_q;
    first_d    = first_q;
    file_d     = file_q;
    wr_d       = wr_q;
    conf_d     = conf_q;
    spend_d    = spend_q;
    tag_d      = tag_q;
    moved_d    = moved_q;
    dsel_d     = dsel_q;
    r_status_d = r_status_q;
    r_class_d  = r_class_q;
    r_oval_d   = r_oval_q;
    r_tag_d    = r_tag_q;
    mv_en      = 1'b0;
    mv_idx     = '0;
    pl_en      = 1'b0;
    pl_idx     = '0;
    app_en     = 1'b0;
    div_start  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          r_status_d = STS_OK;
          r_class_d  = '0;
          r_oval_d   = 1'b0;
          r_tag_d    = '0;
          moved_d    = '0;
          conf_d     = 1'b0;
          k_d        = '0;
          wr_d       = is_write_i;
          file_d     = fmod[file_id_i];
          first_d    = byte_offset_i[39:SHIFT];
          span_d     = SP_W'(nblk);
          tag_d      = request_tag_i;
          spend_d    = (command_i == CMD_PULL);
          if (command_i == CMD_PUSH) begin
            if (cnt_q >= CNT_W'(QUEUE_DEPTH)) begin
              r_status_d = STS_FULL;
              state_d    = S_FIN;
            end else if (nblk > 18'(MAX_SPAN_BLOCKS)) begin
              r_status_d = STS_SPAN;
              state_d    = S_FIN;
            end else begin
              state_d = S_CONF;
            end
          end else if (command_i == CMD_PULL || command_i == CMD_PEEK) begin
            state_d = S_SEL;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_CONF: begin
        if (any_c) conf_d = 1'b1;
        state_d = S_WR;
      end
      S_WR, S_RD: begin
        if (state_q == S_WR && hit_w) begin
          mv_en   = 1'b1;
          mv_idx  = w_idx;
          nw_d    = nw_q - CNT_W'(1);
          nc_d    = nc_q + CNT_W'(1);
          moved_d = moved_q + 6'd1;
          conf_d  = 1'b1;
        end else if (state_q == S_RD && hit_r) begin
          mv_en   = 1'b1;
          mv_idx  = r_idx;
          nr_d    = nr_q - CNT_W'(1);
          nc_d    = nc_q + CNT_W'(1);
          moved_d = moved_q + 6'd1;
          conf_d  = 1'b1;
        end else if (state_q == S_WR && wr_q) begin
          state_d = S_RD;
        end else if (k_q == span_q - SP_W'(1)) begin
          state_d = S_APPEND;
        end else begin
          k_d     = k_q + SP_W'(1);
          state_d = S_CONF;
        end
      end
      S_APPEND: begin
        app_en = 1'b1;
        cnt_d  = cnt_q + CNT_W'(1);
        if (conf_q)    nc_d = nc_q + CNT_W'(1);
        else if (wr_q) nw_d = nw_q + CNT_W'(1);
        else           nr_d = nr_q + CNT_W'(1);
        r_status_d = STS_OK;
        state_d    = S_FIN;
      end
      S_SEL: begin
        if (cnt_q == '0) begin
          r_status_d = STS_EMPTY;
          state_d    = S_FIN;
        end else if (!sel_found) begin
          dsel_d  = CLS_READ;
          state_d = S_DIVGO;
        end else begin
          r_oval_d  = hd_found;
          r_tag_d   = c_tag[hd_idx];
          r_class_d = sel_cls;
          if (spend_q) begin
            unique case (sel_cls)
              CLS_READ:  rb_d = rb_q - BATCH_W'(1);
              CLS_WRITE: wb_d = wb_q - BATCH_W'(1);
              default:   cb_d = cb_q - BATCH_W'(1);
            endcase
            pl_en  = 1'b1;
            pl_idx = hd_idx;
            cnt_d  = cnt_q - CNT_W'(1);
            unique case (sel_cls)
              CLS_READ:  nr_d = nr_q - CNT_W'(1);
              CLS_WRITE: nw_d = nw_q - CNT_W'(1);
              default:   nc_d = nc_q - CNT_W'(1);
            endcase
          end
          state_d = S_FIN;
        end
      end
      S_DIVGO: begin
        div_start = 1'b1;
        state_d   = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (div_done) begin
          unique case (dsel_q)
            CLS_READ:  rb_d = refill;
            CLS_WRITE: wb_d = refill;
            default:   cb_d = refill;
          endcase
          if (dsel_q == CLS_CONFLICT) begin
            state_d = S_SEL;
          end else begin
            dsel_d  = dsel_q + 2'd1;
            state_d = S_DIVGO;
          end
        end
      end
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      nr_q        <= '0;
      nw_q        <= '0;
      nc_q        <= '0;
      rb_q        <= '0;
      wb_q        <= '0;
      cb_q        <= '0;
      batch_q     <= BATCH_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      nr_q    <= nr_d;
      nw_q    <= nw_d;
      nc_q    <= nc_d;
      rb_q    <= rb_d;
      wb_q    <= wb_d;
      cb_q    <= cb_d;
      if (grant_quota_we_i) batch_q <= grant_quota_i;
      if (state_q == S_FIN && out_free) res_valid_q <= 1'b1;
      else if (!res_stall_i)            res_valid_q <= 1'b0;
    end
  end

  // marks a push that completed, for the push-only result fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                 push_done_q <= 1'b0;
    else if (state_q == S_APPEND) push_done_q <= 1'b1;
    else if (state_q == S_IDLE)   push_done_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    span_q     <= span_d;
    first_q    <= first_d;
    file_q     <= file_d;
    wr_q       <= wr_d;
    conf_q     <= conf_d;
    spend_q    <= spend_d;
    tag_q      <= tag_d;
    moved_q    <= moved_d;
    dsel_q     <= dsel_d;
    r_status_q <= r_status_d;
    r_class_q  <= r_class_d;
    r_oval_q   <= r_oval_d;
    r_tag_q    <= r_tag_d;
    if (state_q == S_FIN && out_free) begin
      status_o             <= r_status_q;
      pushed_conflicting_o <= push_done_q && conf_q;
      moved_count_o        <= push_done_q ? moved_q : 6'd0;
      out_valid_o          <= r_oval_q;
      out_tag_o            <= r_tag_q;
      out_class_o          <= r_class_q;
    end
  end

  assign res_valid_o = res_valid_q;

endmodule

FILE: sim/hairq_checker.sv
module hairq_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        grant_quota_we_i,
  input  logic [6:0]  grant_quota_i,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic        is_write_i,
  input  logic [3:0]  file_id_i,
  input  logic [39:0] byte_offset_i,
  input  logic [15:0] byte_length_i,
  input  logic [7:0]  request_tag_i,
  input  logic        res_valid_o,
  input  logic        res_stall_i,
  input  logic [1:0]  status_o,
  input  logic        pushed_conflicting_o,
  input  logic [5:0]  moved_count_o,
  input  logic        out_valid_o,
  input  logic [7:0]  out_tag_o,
  input  logic [1:0]  out_class_o,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import hairq_pkg::*;

  localparam int DEPTH = 32;
  localparam int BLK = 4096;
  localparam int MAX_SPAN = 8;

  typedef struct packed {
    logic [1:0] status;
    logic       conflicting;
    logic [5:0] moved;
    logic       valid;
    logic [7:0] tag;
    logic [1:0] cls;
  } queue_reply_t;

  logic        q_used  [DEPTH];
  logic [7:0]  q_tag   [DEPTH];
  logic [3:0]  q_file  [DEPTH];
  logic [27:0] q_first [DEPTH];
  logic [3:0]  q_span  [DEPTH];
  logic [1:0]  q_cls   [DEPTH];
  int          q_order [DEPTH];
  int          occupancy;
  int          credit [3];
  logic [6:0]  batch;
  queue_reply_t replies[$];

  function automatic int oldest_hit(logic [1:0] c, logic [3:0] f, longint b);
    int best;
    best = -1;
    for (int i = 0; i < DEPTH; i++)
      if (q_used[i] && q_file[i] == f && b >= q_first[i] && b < q_first[i] + q_span[i] &&
          q_cls[i] == c && (best < 0 || q_order[i] < q_order[best]))
        best = i;
    return best;
  endfunction

  function automatic void close_gap(int s);
    for (int j = 0; j < DEPTH; j++)
      if (q_used[j] && q_order[j] > s) q_order[j]--;
  endfunction

  function automatic int head_of(logic [1:0] c);
    int best;
    best = -1;
    for (int i = 0; i < DEPTH; i++)
      if (q_used[i] && q_cls[i] == c && (best < 0 || q_order[i] < q_order[best])) best = i;
    return best;
  endfunction

  function automatic int choose_class(bit spend);
    int n[3];
    int total;
    int v;
    n = '{0, 0, 0};
    for (int i = 0; i < DEPTH; i++) if (q_used[i]) n[q_cls[i]]++;
    total = n[0] + n[1] + n[2];
    if (total == 0) return -1;
    for (int pass = 0; pass < 2; pass++) begin
      for (int c = 0; c < 3; c++)
        if (credit[c] > 0 && n[c] > 0) begin
          if (spend) credit[c]--;
          return c;
        end
      for (int c = 0; c < 3; c++) begin
        v = n[c] * int'(batch) / total;
        credit[c] = v < 1 ? 1 : v;
      end
    end
    return -1;
  endfunction

  function automatic queue_reply_t predict_reply(logic [1:0] cmd, logic wr, logic [3:0] f,
                                                 logic [39:0] off, logic [15:0] len,
                                                 logic [7:0] tag);
    queue_reply_t r;
    longint first, room, rest, n, b;
    int i, c, h, moved, slot;
    bit confl;
    r = '0;
    if (cmd == CMD_PUSH) begin
      first = off / BLK;
      room = BLK - (off % BLK);
      rest = len - (len < room ? len : room);
      n = 1 + (rest + BLK - 1) / BLK;
      if (occupancy >= DEPTH) begin
        r.status = STS_FULL;
        return r;
      end
      if (n > MAX_SPAN) begin
        r.status = STS_SPAN;
        return r;
      end
      confl = 0;
      moved = 0;
      for (longint k = 0; k < n; k++) begin
        b = first + k;
        if (oldest_hit(CLS_CONFLICT, f, b) >= 0) confl = 1;
        for (int pass = 0; pass < 2; pass++) begin
          if (pass == 1 && !wr) break;
          forever begin
            i = oldest_hit(pass == 0 ? CLS_WRITE : CLS_READ, f, b);
            if (i < 0) break;
            close_gap(q_order[i]);
            q_order[i] = occupancy - 1;
            q_cls[i] = CLS_CONFLICT;
            moved++;
            confl = 1;
          end
        end
      end
      slot = -1;
      for (int j = DEPTH - 1; j >= 0; j--) if (!q_used[j]) slot = j;
      q_used[slot] = 1;
      q_tag[slot] = tag;
      q_file[slot] = f;
      q_first[slot] = first[27:0];
      q_span[slot] = n[3:0];
      q_cls[slot] = confl ? CLS_CONFLICT : (wr ? CLS_WRITE : CLS_READ);
      q_order[slot] = occupancy;
      occupancy++;
      r.conflicting = confl;
      r.moved = moved[5:0];
    end else if (cmd == CMD_PULL || cmd == CMD_PEEK) begin
      c = choose_class(cmd == CMD_PULL);
      if (c < 0) r.status = STS_EMPTY;
      else begin
        h = head_of(c[1:0]);
        r.valid = 1;
        r.tag = q_tag[h];
        r.cls = c[1:0];
        if (cmd == CMD_PULL) begin
          close_gap(q_order[h]);
          q_used[h] = 0;
          occupancy--;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    queue_reply_t e;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) q_used[i] = 0;
      occupancy = 0;
      credit = '{0, 0, 0};
      batch = BATCH_RESET;
      replies.delete();
      pending = 0;
      fail_count = 0;
    end else begin
      if (grant_quota_we_i) batch = grant_quota_i;
      if (in_valid_i && !in_stall_o)
        replies.insert(replies.size(),
                       predict_reply(command_i, is_write_i, file_id_i, byte_offset_i,
                                     byte_length_i, request_tag_i));
      if (res_valid_o && !res_stall_i) begin
        if (replies.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          e = replies.pop_front();
          if (status_o !== e.status) begin
            $error("status expected %0d actual %0d", e.status, status_o);
            fail_count++;
          end
          if (pushed_conflicting_o !== e.conflicting) begin
            $error("pushed_conflicting expected %0d actual %0d", e.conflicting,
                   pushed_conflicting_o);
            fail_count++;
          end
          if (moved_count_o !== e.moved) begin
            $error("moved_count expected %0d actual %0d", e.moved, moved_count_o);
            fail_count++;
          end
          if (out_valid_o !== e.valid) begin
            $error("out_valid expected %0d actual %0d", e.valid, out_valid_o);
            fail_count++;
          end
          if (out_tag_o !== e.tag) begin
            $error("out_tag expected %0d actual %0d", e.tag, out_tag_o);
            fail_count++;
          end
          if (out_class_o !== e.cls) begin
            $error("out_class expected %0d actual %0d", e.cls, out_class_o);
            fail_count++;
          end
        end
      end
      pending = replies.size();
    end
  end
endmodule

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hairq_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        grant_quota_we_i = 0;
  logic [6:0]  grant_quota_i = '0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  command_i = '0;
  logic        is_write_i = 0;
  logic [3:0]  file_id_i = '0;
  logic [39:0] byte_offset_i = '0;
  logic [15:0] byte_length_i = '0;
  logic [7:0]  request_tag_i = '0;
  logic        res_valid_o;
  logic        res_stall_i = 0;
  logic [1:0]  status_o;
  logic        pushed_conflicting_o;
  logic [5:0]  moved_count_o;
  logic        out_valid_o;
  logic [7:0]  out_tag_o;
  logic [1:0]  out_class_o;
  int          fail_count;
  int          pending;

  hazard_aware_io_reorder_queue uut (.*);
  hairq_checker chk (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side stalls at random, with calm stretches
  initial begin
    int hold;
    forever begin
      @(negedge clk_i);
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        res_stall_i <= 1;
        repeat (hold) @(negedge clk_i);
      end
      res_stall_i <= 0;
      do @(posedge clk_i); while (!res_valid_o);
    end
  end

  // valid stays up into the next beat, so it only drops for a gap or an idle beat
  task automatic send_beat(logic [1:0] cmd, logic wr, logic [3:0] f, logic [39:0] off,
                           logic [15:0] len, logic [7:0] tag, int gap);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    command_i <= cmd;
    is_write_i <= wr;
    file_id_i <= f;
    byte_offset_i <= off;
    byte_length_i <= len;
    request_tag_i <= tag;
    in_valid_i <= 1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic idle_beat();
    in_valid_i <= 0;
    @(negedge clk_i);
  endtask

  task automatic set_batch(logic [6:0] v);
    idle_beat();
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    grant_quota_we_i <= 1;
    grant_quota_i <= v;
    @(negedge clk_i);
    grant_quota_we_i <= 0;
  endtask

  task automatic random_beat(int gap);
    int pick;
    logic [39:0] off;
    logic [15:0] len;
    pick = $urandom_range(0, 99);
    // narrow region of blocks so spans collide often
    off = {$urandom_range(0, 1) ? 26'h3FFFFFF : 26'h0, 14'($urandom_range(0, 12) * 1024)}
          ^ ($urandom_range(0, 19) == 0 ? 40'({$urandom, $urandom}) : 40'h0);
    len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12000));
    if (pick < 48)
      send_beat(CMD_PUSH, 1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0 ?
                4'($urandom) : 4'($urandom_range(0, 1)), off, len, 8'($urandom), gap);
    else if (pick < 85)
      send_beat(CMD_PULL, 1'($urandom), 4'($urandom), 40'({$urandom, $urandom}),
                16'($urandom), 8'($urandom), gap);
    else if (pick < 98)
      send_beat(CMD_PEEK, 1'($urandom), 4'($urandom), 40'({$urandom, $urandom}),
                16'($urandom), 8'($urandom), gap);
    else
      send_beat(CMD_UNUSED, 1'($urandom), 4'($urandom), 40'({$urandom, $urandom}),
                16'($urandom), 8'($urandom), gap);
  endtask

  initial begin
    logic [6:0] settings[4];
    int gap;
    settings = '{7'd1, 7'd64, 7'd0, 7'd127};
    repeat (12) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // directed: empty, extremes, overlaps, over-span, a full queue and its drain
    send_beat(CMD_PULL, 1'b0, 4'h0, 40'd0, 16'd0, 8'h00, 0);
    send_beat(CMD_PEEK, 1'b0, 4'h0, 40'd0, 16'd0, 8'h00, 0);
    send_beat(CMD_UNUSED, 1'b1, 4'hF, '1, '1, '1, 0);
    send_beat(CMD_PUSH, 1'b0, 4'h0, 40'd0, 16'd0, 8'h00, 0);
    send_beat(CMD_PUSH, 1'b0, 4'h0, 40'd4095, 16'd1, 8'h01, 1);
    send_beat(CMD_PUSH, 1'b1, 4'hF, 40'hFF_FFFF_F000, 16'd4096, 8'hFF, 0);
    send_beat(CMD_PUSH, 1'b0, 4'h0, 40'd100, 16'd32768, 8'h02, 0);
    send_beat(CMD_PUSH, 1'b1, 4'h0, 40'd0, 16'd32768, 8'h03, 0);
    send_beat(CMD_PUSH, 1'b0, 4'h0, 40'd8192, 16'd10, 8'h04, 2);
    send_beat(CMD_PUSH, 1'b1, 4'h0, 40'd0, 16'hFFFF, 8'h05, 0);
    send_beat(CMD_PUSH, 1'b1, 4'h0, 40'd4096, 16'd28672, 8'h06, 0);
    send_beat(CMD_PEEK, 1'b0, 4'h0, 40'd0, 16'd0, 8'h00, 0);
    repeat (6) send_beat(CMD_PULL, 1'b0, 4'h0, 40'd0, 16'd0, 8'h00, 0);
    for (int t = 0; t < 33; t++)
      send_beat(CMD_PUSH, t[0], 4'(t), 40'(t) << 12, 16'd0, 8'(t), 0);
    for (int t = 0; t < 33; t++) send_beat(CMD_PULL, 1'b0, 4'h0, 40'd0, 16'd0, 8'h00, 0);
    for (int ph = 0; ph < 5; ph++) begin
      if (ph < 4) set_batch(settings[ph]);
      else set_batch(7'd32);
      for (int n = 0; n < 364; n++) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        random_beat(gap);
        if (n == 190 && ph == 2) begin
          idle_beat();
          while (pending != 0) @(negedge clk_i);
        end
      end
    end
    idle_beat();
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

FILE: files.f
rtl/hairq_pkg.sv
rtl/hairq_cell.sv
rtl/hairq_div.sv
rtl/hazard_aware_io_reorder_queue.sv
sim/hairq_checker.sv
sim/tb_top.sv
